// File: sv/hsj_pkg.sv
// Shared types and constants for the five-point heat stencil step unit.
package hsj_pkg;

    localparam int TEMP_W  = 16;   // temperature field width on the ports
    localparam int GRID_W  = 9;
    localparam int COORD_W = 8;
    localparam int GAIN_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MIN_GRID   = 2;
    localparam int ROUND_SHIFT = 16;  // alpha is Q0.16

    localparam logic [GRID_W-1:0]  GRID_SIZE_RST  = 9'd256;
    localparam logic [COORD_W-1:0] SOURCE_ROW_RST = 8'd64;
    localparam logic [COORD_W-1:0] SOURCE_COL_RST = 8'd64;
    localparam logic [GAIN_W-1:0]  GAIN_RST       = 16'd13107;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SIZE  = 2'd0,
        CFG_SOURCE_ROW = 2'd1,
        CFG_SOURCE_COL = 2'd2,
        CFG_DIFF_GAIN  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [GRID_W-1:0]  grid_size;
        logic [COORD_W-1:0] source_row;
        logic [COORD_W-1:0] source_col;
        logic [GAIN_W-1:0]  diffusion_gain;
    } t_cfg;

    typedef struct packed {
        logic              req_type;
        logic [TEMP_W-1:0] cell_temp;
    } t_in;

    typedef struct packed {
        logic [TEMP_W-1:0] new_temp;
        logic              last_of_frame;
    } t_out;

    // Window to datapath control
    typedef struct packed {
        logic emit;      // this word yields a result
        logic is_src;    // heat source cell, passes through
        logic last;      // final cell of the frame
    } t_win_ctl;

endpackage

// File: sv/hsj_cell.sv
// One pipeline cell: holds a word and hands it on, collapsing bubbles.
module hsj_cell #(
    parameter type T = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  T     i_data,
    output logic o_valid,
    input  logic i_ready,
    output T     o_data
);

    logic r_valid;
    T     r_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

// File: sv/hsj_window.sv
// Row stores, grid counters and the stencil window fed from them.
module hsj_window import hsj_pkg::*; #(
    parameter int MAX_GRID  = 256,
    parameter int TEMP_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc,
    input  logic                 i_drain,
    input  logic [TEMP_BITS-1:0] i_temp,
    input  t_cfg                 i_cfg,
    output t_win_ctl             o_ctl,
    output logic [TEMP_BITS-1:0] o_tc,
    output logic [TEMP_BITS+1:0] o_sum
);

    localparam int CW = $clog2(MAX_GRID);
    localparam int NW = $clog2(MAX_GRID + 1);
    localparam int LW = ((NW > GRID_W) ? NW : GRID_W) + 1;
    localparam int SW = TEMP_BITS + 2;

    logic [TEMP_BITS-1:0] upper_mem  [MAX_GRID];
    logic [TEMP_BITS-1:0] middle_mem [MAX_GRID];

    logic [CW-1:0]        r_col, n_col, r_row;
    logic                 r_draining;
    logic [TEMP_BITS-1:0] r_mc, r_mr, r_up, r_prev, r_tbyp;
    logic                 r_byp;

    logic [LW-1:0]        side, orow;
    logic                 act, last_col, last_row, upd;
    logic [TEMP_BITS-1:0] lv, rv, uv, dv, m_right;
    logic [CW-1:0]        col_ahead;

    always_comb begin
        priority if (LW'(i_cfg.grid_size) < LW'(MIN_GRID)) begin
            side = LW'(MIN_GRID);
        end else if (LW'(i_cfg.grid_size) > LW'(MAX_GRID)) begin
            side = LW'(MAX_GRID);
        end else begin
            side = LW'(i_cfg.grid_size);
        end
    end

    assign act      = i_drain ? r_draining : !r_draining;
    assign upd      = i_acc && act;
    assign last_col = (LW'(r_col) + LW'(1)) >= side;
    assign last_row = (LW'(r_row) + LW'(1)) >= side;
    assign n_col    = last_col ? '0 : r_col + CW'(1);
    assign col_ahead = n_col + CW'(1);

    // right neighbour may be the word written by the update that read it ahead
    assign m_right = r_byp ? r_tbyp : r_mr;

    always_comb begin
        lv   = (r_col != '0) ? r_prev : r_mc;
        rv   = last_col ? r_mc : m_right;
        uv   = (!i_drain && r_row == CW'(1)) ? r_mc : r_up;
        dv   = i_drain ? r_mc : i_temp;
        orow = i_drain ? side - LW'(1) : LW'(r_row) - LW'(1);
    end

    assign o_tc  = r_mc;
    assign o_sum = SW'(lv) + SW'(rv) + SW'(uv) + SW'(dv);
    assign o_ctl.emit   = act && (i_drain || r_row != '0);
    assign o_ctl.is_src = (orow == LW'(i_cfg.source_row)) && (LW'(r_col) == LW'(i_cfg.source_col));
    assign o_ctl.last   = i_drain && last_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_draining <= 1'b0;
        end else if (upd) begin
            r_col <= n_col;
            if (last_col) begin
                if (i_drain) begin
                    r_draining <= 1'b0;
                    r_row      <= '0;
                end else if (last_row) begin
                    r_draining <= 1'b1;
                    r_row      <= '0;
                end else begin
                    r_row <= r_row + CW'(1);
                end
            end
        end
    end

    // stores and read-ahead of the next column's window
    always_ff @(posedge i_clk) begin
        if (upd) begin
            upper_mem[r_col] <= r_mc;
            if (!i_drain) begin
                middle_mem[r_col] <= i_temp;
            end
            r_mc   <= middle_mem[n_col];
            r_mr   <= middle_mem[col_ahead];
            r_up   <= upper_mem[n_col];
            r_prev <= r_mc;
            r_tbyp <= i_temp;
            r_byp  <= !i_drain && (col_ahead == r_col);
        end
    end

    a_drain_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> r_row == '0)
        else $error("row counter not cleared while draining");

    a_byp_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(upd) && r_byp |-> r_col == '0)
        else $error("right bypass outside a row wrap");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd && i_drain && last_col |=> !r_draining && r_col == '0 && r_row == '0)
        else $error("frame end did not return counters to origin");

endmodule

// File: sv/heat_stencil_2d_jacobi_step_unit.sv
// Top level of the five-point Jacobi heat stencil step unit.
// While the output is not stalled, takes one grid word per clock (row-major
// cells, then drain ticks for the last row) and returns one word per clock:
// the result for a cell of row r is issued when the cell of row r+1 in the
// same column (or its drain tick) is accepted, and reaches the output via a
// chain of four handshake cells (operand sum, difference, gain multiply,
// round and saturate). Two row stores of MAX_GRID words each, read one
// column ahead, feed the window; they need no clearing after reset. Row zero
// and ignored words give no result. Configuration is taken on any cycle.
module heat_stencil_2d_jacobi_step_unit import hsj_pkg::*; #(
    parameter int MAX_GRID  = 256,
    parameter int TEMP_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TB = TEMP_BITS;
    localparam int DW = TB + 3;
    localparam int PW = DW + GAIN_W + 1;
    localparam int RW = PW - ROUND_SHIFT;
    localparam logic signed [PW-1:0] ROUND = PW'(1 << (ROUND_SHIFT - 1));

    typedef struct packed {
        logic [TB-1:0]   tc;
        logic [TB+1:0]   sum;
        logic            src;
        logic            last;
    } t_s1;

    typedef struct packed {
        logic [TB-1:0]        tc;
        logic signed [DW-1:0] d;
        logic                 src;
        logic                 last;
    } t_s2;

    typedef struct packed {
        logic [TB-1:0]        tc;
        logic signed [PW-1:0] p;
        logic                 src;
        logic                 last;
    } t_s3;

    t_cfg     r_cfg;
    t_win_ctl w_ctl;
    logic [TB-1:0]   w_tc;
    logic [TB+1:0]   w_sum;
    logic            acc;

    t_s1  s1_in, s1_out;
    t_s2  s2_in, s2_out;
    t_s3  s3_in, s3_out;
    t_out s4_in;
    logic v1, v2, v3, rdy1, rdy2, rdy3, rdy4;

    logic signed [PW-1:0] w_rnd;
    logic signed [RW-1:0] w_delta, w_res;
    logic [TB-1:0]        w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_size      <= GRID_SIZE_RST;
            r_cfg.source_row     <= SOURCE_ROW_RST;
            r_cfg.source_col     <= SOURCE_COL_RST;
            r_cfg.diffusion_gain <= GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GRID_SIZE:  r_cfg.grid_size      <= i_cfg_data[GRID_W-1:0];
                CFG_SOURCE_ROW: r_cfg.source_row     <= i_cfg_data[COORD_W-1:0];
                CFG_SOURCE_COL: r_cfg.source_col     <= i_cfg_data[COORD_W-1:0];
                CFG_DIFF_GAIN:  r_cfg.diffusion_gain <= i_cfg_data[GAIN_W-1:0];
            endcase
        end
    end

    assign o_in_ready = rdy1;
    assign acc        = i_in_valid && o_in_ready;

    hsj_window #(
        .MAX_GRID  (MAX_GRID),
        .TEMP_BITS (TEMP_BITS)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_drain (i_in.req_type),
        .i_temp  (TB'(i_in.cell_temp)),
        .i_cfg   (r_cfg),
        .o_ctl   (w_ctl),
        .o_tc    (w_tc),
        .o_sum   (w_sum)
    );

    always_comb begin
        s1_in.tc   = w_tc;
        s1_in.sum  = w_sum;
        s1_in.src  = w_ctl.is_src;
        s1_in.last = w_ctl.last;
    end

    hsj_cell #(.T(t_s1)) u_cell_sum (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (acc && w_ctl.emit), .o_ready (rdy1), .i_data (s1_in),
        .o_valid (v1), .i_ready (rdy2), .o_data (s1_out)
    );

    // neighbour sum less four times the centre
    always_comb begin
        s2_in.tc   = s1_out.tc;
        s2_in.d    = DW'(s1_out.sum) - (DW'(s1_out.tc) << 2);
        s2_in.src  = s1_out.src;
        s2_in.last = s1_out.last;
    end

    hsj_cell #(.T(t_s2)) u_cell_diff (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (v1), .o_ready (rdy2), .i_data (s2_in),
        .o_valid (v2), .i_ready (rdy3), .o_data (s2_out)
    );

    always_comb begin
        s3_in.tc   = s2_out.tc;
        s3_in.p    = s2_out.d * $signed({1'b0, r_cfg.diffusion_gain});
        s3_in.src  = s2_out.src;
        s3_in.last = s2_out.last;
    end

    hsj_cell #(.T(t_s3)) u_cell_mul (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (v2), .o_ready (rdy3), .i_data (s3_in),
        .o_valid (v3), .i_ready (rdy4), .o_data (s3_out)
    );

    // source cells pass; else round half up, add to centre, clamp to temp range
    always_comb begin
        w_rnd   = s3_out.p + ROUND;
        w_delta = w_rnd[PW-1:ROUND_SHIFT];
        w_res   = $signed(RW'(s3_out.tc)) + w_delta;
        priority if (s3_out.src) begin
            w_sat = s3_out.tc;
        end else if (w_res[RW-1]) begin
            w_sat = '0;
        end else if (w_res[RW-2:TB] != '0) begin
            w_sat = '1;
        end else begin
            w_sat = w_res[TB-1:0];
        end
        s4_in.new_temp      = TEMP_W'(w_sat);
        s4_in.last_of_frame = s3_out.last;
    end

    hsj_cell #(.T(t_out)) u_cell_out (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (v3), .o_ready (rdy4), .i_data (s4_in),
        .o_valid (o_out_valid), .i_ready (i_out_ready), .o_data (o_out)
    );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the five-point Jacobi heat stencil step unit.
`timescale 1ns / 1ps

module tb_top;
    import hsj_pkg::*;

    localparam int GRID_MAX  = 256;
    localparam int TAIL_WAIT = 12;    // pipeline depth plus margin
    localparam int HANG_LIMIT = 2000;
    localparam int RAND_WORDS = 1500;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid  = 1'b0;
    t_in                   in_word   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    t_cfg_idx              cfg_idx   = CFG_GRID_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    heat_stencil_2d_jacobi_step_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor: own copy of the row stores, counters and settings
    // ---------------------------------------------------------------
    logic [TEMP_W-1:0]  upper_row [GRID_MAX] = '{default: '0};
    logic [TEMP_W-1:0]  middle_row [GRID_MAX] = '{default: '0};
    int unsigned        row_cnt   = 0;
    int unsigned        col_cnt   = 0;
    int unsigned        flush_col = 0;
    bit                 flushing  = 1'b0;
    logic [GRID_W-1:0]  set_grid  = GRID_SIZE_RST;
    logic [COORD_W-1:0] set_srow  = SOURCE_ROW_RST;
    logic [COORD_W-1:0] set_scol  = SOURCE_COL_RST;
    logic [GAIN_W-1:0]  set_gain  = GAIN_RST;

    t_out grid_words_out [$];   // expected updated cells, oldest first
    t_in  grid_words_in [$];    // words waiting for the driver
    int   mismatches = 0;
    bit   quiet = 1'b0;         // no idling on either side

    function automatic int unsigned grid_side();
        if (set_grid < GRID_W'(MIN_GRID)) return MIN_GRID;
        if (set_grid > GRID_W'(GRID_MAX)) return GRID_MAX;
        return set_grid;
    endfunction

    function automatic logic [TEMP_W-1:0] heat_update(input int unsigned orow,
                                                      input int unsigned col,
                                                      input logic [TEMP_W-1:0] down,
                                                      input bit top_edge,
                                                      input int unsigned n);
        longint tc, lv, rv, uv, dv, p, res;
        tc = longint'(middle_row[col]);
        if (orow == set_srow && col == set_scol) return middle_row[col];
        lv = (col > 0) ? longint'(upper_row[col-1]) : tc;
        rv = (col + 1 < n) ? longint'(middle_row[col+1]) : tc;
        uv = top_edge ? tc : longint'(upper_row[col]);
        dv = longint'(down);
        p = (lv + rv + uv + dv - 4 * tc) * longint'(set_gain) + 32768;
        res = tc + (p >>> ROUND_SHIFT);   // arithmetic shift floors
        if (res < 0) res = 0;
        if (res > 65535) res = 65535;
        return res[TEMP_W-1:0];
    endfunction

    task automatic predict_word(input t_in w);
        int unsigned n, r, c, d;
        t_out        res;
        n = grid_side();
        if (w.req_type) begin
            if (flushing) begin
                d = flush_col;
                res.new_temp      = heat_update(n - 1, d, middle_row[d], 1'b0, n);
                res.last_of_frame = (d + 1 >= n);
                grid_words_out.push_back(res);
                upper_row[d] = middle_row[d];
                if (d + 1 >= n) begin
                    flushing  = 1'b0;
                    flush_col = 0;
                    row_cnt   = 0;
                    col_cnt   = 0;
                end else begin
                    flush_col = d + 1;
                end
            end
        end else if (!flushing) begin
            r = row_cnt;
            c = col_cnt;
            if (r > 0) begin
                res.new_temp      = heat_update(r - 1, c, w.cell_temp, r == 1, n);
                res.last_of_frame = 1'b0;
                grid_words_out.push_back(res);
            end
            upper_row[c]  = middle_row[c];
            middle_row[c] = w.cell_temp;
            if (c + 1 >= n) begin
                col_cnt = 0;
                if (r + 1 >= n) begin
                    row_cnt   = 0;
                    flushing  = 1'b1;
                    flush_col = 0;
                end else begin
                    row_cnt = r + 1;
                end
            end else begin
                col_cnt = c + 1;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Idling
    // ---------------------------------------------------------------
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------
    // Driver
    // ---------------------------------------------------------------
    int send_gap = 0;

    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!in_valid || o_in_ready) begin
            if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (grid_words_in.size() > 0) begin
                in_valid <= 1'b1;
                in_word  <= grid_words_in.pop_front();
                send_gap <= idle_len();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    int stall_left = 0;

    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= idle_len();
        end
    end

    // ---------------------------------------------------------------
    // Monitor and checker
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out exp_word;
        if (rst_n) begin
            if (in_valid && o_in_ready) predict_word(in_word);
            if (o_out_valid && out_ready) begin
                if (grid_words_out.size() == 0) begin
                    $error("unexpected word: new_temp %0d last_of_frame %0d",
                           o_out.new_temp, o_out.last_of_frame);
                    mismatches++;
                end else begin
                    exp_word = grid_words_out.pop_front();
                    if (o_out.new_temp !== exp_word.new_temp) begin
                        $error("new_temp: expected %0d, got %0d",
                               exp_word.new_temp, o_out.new_temp);
                        mismatches++;
                    end
                    if (o_out.last_of_frame !== exp_word.last_of_frame) begin
                        $error("last_of_frame: expected %0d, got %0d",
                               exp_word.last_of_frame, o_out.last_of_frame);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no traffic at all
    int hang_cnt = 0;

    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready) || cfg_we) begin
            hang_cnt <= 0;
        end else if (hang_cnt >= HANG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            hang_cnt <= hang_cnt + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic push_word(input logic kind, input logic [TEMP_W-1:0] temp);
        t_in w;
        w.req_type  = kind;
        w.cell_temp = temp;
        grid_words_in.push_back(w);
    endtask

    function automatic logic [TEMP_W-1:0] pick_temp();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return TEMP_W'($urandom);
            default: return TEMP_W'(17472 + $urandom_range(0, 4000));
        endcase
    endfunction

    task automatic wait_idle();
        while (grid_words_in.size() != 0 || in_valid || grid_words_out.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    // Writes all four registers once the unit has gone quiet
    task automatic load_settings(input logic [CFG_DATA_W-1:0] n_raw,
                                 input logic [CFG_DATA_W-1:0] row_raw,
                                 input logic [CFG_DATA_W-1:0] col_raw,
                                 input logic [CFG_DATA_W-1:0] gain_raw);
        logic [CFG_DATA_W-1:0] vals [4];
        vals = '{n_raw, row_raw, col_raw, gain_raw};
        wait_idle();
        for (int i = 0; i < 4; i++) begin
            @(posedge i_clk);
            cfg_we   <= 1'b1;
            cfg_idx  <= t_cfg_idx'(i);
            cfg_data <= vals[i];
        end
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        set_grid = n_raw[GRID_W-1:0];
        set_srow = row_raw[COORD_W-1:0];
        set_scol = col_raw[COORD_W-1:0];
        set_gain = gain_raw[GAIN_W-1:0];
        quiet    = ($urandom_range(0, 4) == 0);
    endtask

    // A whole frame: cells in row-major order then the flushing drain ticks.
    // Noise words are ones the unit must ignore.
    task automatic queue_frame(input int n, input int noise_pct);
        for (int k = 0; k < n * n; k++) begin
            if ($urandom_range(0, 99) < noise_pct) push_word(1'b1, TEMP_W'($urandom));
            push_word(1'b0, pick_temp());
        end
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < noise_pct) push_word(1'b0, TEMP_W'($urandom));
            push_word(1'b1, TEMP_W'($urandom));
        end
    endtask

    initial begin
        int                    sent;
        int                    n;
        logic [CFG_DATA_W-1:0] gain;

        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        // smallest grid (size 0 clamps), full gain, source in the corner,
        // drain while idle, extreme temps, cell while flushing
        load_settings(16'd0, 16'd0, 16'd0, 16'hFFFF);
        push_word(1'b1, 16'hFFFF);
        push_word(1'b0, 16'h0000);
        push_word(1'b0, 16'hFFFF);
        push_word(1'b0, 16'hFFFF);
        push_word(1'b0, 16'h0000);
        push_word(1'b0, 16'h1234);
        push_word(1'b1, 16'h0000);
        push_word(1'b1, 16'hFFFF);

        // size 1 clamps, junk in upper data bits, source outside the grid, zero gain
        load_settings({7'h7F, 9'd1}, 16'hFFFF, 16'h00FF, 16'h0000);
        push_word(1'b0, 16'h5555);
        push_word(1'b0, 16'hAAAA);
        push_word(1'b0, 16'h8001);
        push_word(1'b0, 16'h7FFE);
        push_word(1'b1, 16'h0000);
        push_word(1'b1, 16'h0000);

        // grid shrinks mid-frame: counters past the new edge end row and frame
        load_settings(16'd4, 16'd1, 16'd1, 16'd13107);
        for (int k = 0; k < 10; k++) push_word(1'b0, pick_temp());
        load_settings(16'd2, 16'd1, 16'd1, 16'd13107);
        push_word(1'b0, pick_temp());
        push_word(1'b1, 16'h0000);
        push_word(1'b1, 16'h0000);

        sent = 0;
        while (sent < RAND_WORDS) begin
            if (sent == 0 || $urandom_range(0, 2) == 0) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24)
                                                : $urandom_range(2, 10);
                case ($urandom_range(0, 9))
                    0:       gain = 16'h0000;
                    1:       gain = 16'hFFFF;
                    2, 3, 4: gain = 16'd13107 + 16'($urandom_range(0, 2000)) - 16'd1000;
                    default: gain = 16'($urandom);
                endcase
                load_settings({7'($urandom), 9'(n)},
                              ($urandom_range(0, 3) != 0) ?
                                  {8'($urandom), 8'($urandom_range(0, n - 1))} :
                                  16'($urandom),
                              ($urandom_range(0, 3) != 0) ?
                                  {8'($urandom), 8'($urandom_range(0, n - 1))} :
                                  16'($urandom),
                              gain);
            end
            n = grid_side();
            queue_frame(n, ($urandom_range(0, 2) == 0) ? 5 : 0);
            sent += n * n + n;
        end

        // widest grid: one full row and part of the next, source in row zero,
        // then the grid shrinks so the frame ends early
        load_settings({7'h55, 9'd256}, {8'hA5, 8'd0}, {8'h5A, 8'd200}, 16'd13107);
        for (int k = 0; k < GRID_MAX + 44; k++) push_word(1'b0, pick_temp());
        load_settings(16'd2, 16'd1, 16'd1, 16'd13107);
        push_word(1'b0, pick_temp());
        push_word(1'b1, 16'h0000);
        push_word(1'b1, 16'h0000);

        wait_idle();
        if (mismatches == 0 && grid_words_out.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
sv/hsj_pkg.sv
sv/hsj_cell.sv
sv/hsj_window.sv
sv/heat_stencil_2d_jacobi_step_unit.sv
tb/tb_top.sv
